@@ src/skf_pkg.sv @@
package skf_pkg;

   localparam int DATA_W   = 32;
   localparam int NOISE_W  = 24;
   localparam int THRESH_W = 31;
   localparam int GAIN_W   = 16;
   localparam int FRAC_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;

   // one quotient bit per divider step
   localparam int DIV_STEPS = GAIN_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [NOISE_W-1:0]  PROCESS_NOISE_RST     = 24'd655;
   localparam logic [NOISE_W-1:0]  MEASUREMENT_NOISE_RST = 24'd19661;
   localparam logic [THRESH_W-1:0] JUMP_THRESHOLD_RST    = 31'd524288;

   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASUREMENT_NOISE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_THRESHOLD    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic mul;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_full;
   } status_type;

endpackage

@@ src/skf_csr.sv @@
module skf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [skf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [skf_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic [skf_pkg::NOISE_W-1:0]      process_noise,
   output logic [skf_pkg::NOISE_W-1:0]      measurement_noise,
   output logic [skf_pkg::THRESH_W-1:0]     jump_threshold
);

   logic [skf_pkg::NOISE_W-1:0]  q_ff;
   logic [skf_pkg::NOISE_W-1:0]  r_ff;
   logic [skf_pkg::THRESH_W-1:0] thr_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff   <= skf_pkg::PROCESS_NOISE_RST;
         r_ff   <= skf_pkg::MEASUREMENT_NOISE_RST;
         thr_ff <= skf_pkg::JUMP_THRESHOLD_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            skf_pkg::CSR_PROCESS_NOISE:     q_ff   <= csr_data[skf_pkg::NOISE_W-1:0];
            skf_pkg::CSR_MEASUREMENT_NOISE: r_ff   <= csr_data[skf_pkg::NOISE_W-1:0];
            skf_pkg::CSR_JUMP_THRESHOLD:    thr_ff <= csr_data[skf_pkg::THRESH_W-1:0];
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   assign process_noise     = q_ff;
   assign measurement_noise = r_ff;
   assign jump_threshold    = thr_ff;

endmodule

@@ src/skf_ctrl.sv @@
module skf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 rsp_stall,
   input  skf_pkg::status_type  status,
   output skf_pkg::cmd_type     cmd
);

   skf_pkg::state_type state_ff, state_in;
   logic [skf_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skf_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         skf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = skf_pkg::ST_DIV;
            end
         end
         skf_pkg::ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == skf_pkg::DIV_CNT_W'(skf_pkg::DIV_STEPS - 1)) begin
               state_in = skf_pkg::ST_MUL;
            end
         end
         skf_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = skf_pkg::ST_DONE;
         end
         skf_pkg::ST_DONE: begin
            // hold until the output register can take the result
            if (!(status.out_full && rsp_stall)) begin
               cmd.commit = 1'b1;
               state_in   = skf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skf_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.mul, cmd.commit}))
      else $error("more than one datapath command");
   a_load_div: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == skf_pkg::ST_DIV) && (cnt_ff == '0))
      else $error("load did not start the divider");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(status.out_full && rsp_stall))
      else $error("commit would overwrite a waiting result");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skf_pkg::ST_MUL) |-> $past(state_ff) == skf_pkg::ST_DIV)
      else $error("multiply entered without divider");
`endif

endmodule

@@ src/skf_dp.sv @@
module skf_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  skf_pkg::cmd_type                 cmd,
   output skf_pkg::status_type              status,
   input  logic signed [skf_pkg::DATA_W-1:0] req_sample,
   input  logic [skf_pkg::NOISE_W-1:0]      process_noise,
   input  logic [skf_pkg::NOISE_W-1:0]      measurement_noise,
   input  logic [skf_pkg::THRESH_W-1:0]     jump_threshold,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic signed [skf_pkg::DATA_W-1:0] rsp_estimate,
   output logic                             rsp_jumped
);

   localparam int W  = skf_pkg::DATA_W;
   localparam int G  = skf_pkg::GAIN_W;
   localparam int F  = skf_pkg::FRAC_W;
   localparam int PW = G + 1 + W + 1;   // gain times difference
   localparam int CW = G + 1 + W;       // (1-gain) times covariance

   // filter state
   logic signed [W-1:0] est_ff;
   logic [W-1:0]        cov_ff;

   // per-item working registers
   logic signed [W-1:0] base_ff;
   logic signed [W:0]   diff_ff;
   logic                jumped_ff;
   logic [W-1:0]        pn_ff;
   logic [W:0]          den_ff;
   logic [W:0]          rem_ff;
   logic [G-1:0]        quo_ff;
   logic                rzero_ff;
   logic signed [PW-1:0] prod_ff;
   logic [CW-1:0]       cprod_ff;

   // output register
   logic                out_valid_ff;
   logic signed [W-1:0] out_est_ff;
   logic                out_jump_ff;

   logic signed [W:0]   d;
   logic [W:0]          ad;
   logic                jump;
   logic [W:0]          pn_sum;
   logic [W-1:0]        pn;
   logic [W+1:0]        trial;
   logic                ge;
   logic [G-1:0]        gain;
   logic signed [PW-1:0] prod;
   logic [CW-1:0]       cprod;
   logic signed [W+2:0] sum;
   logic signed [W-1:0] est_new;
   logic [W-1:0]        cov_new;

   always_comb begin
      d    = $signed({req_sample[W-1], req_sample}) - $signed({est_ff[W-1], est_ff});
      ad   = d[W] ? (W+1)'(-d) : d;
      jump = ad >= {2'b00, jump_threshold};

      pn_sum = {1'b0, cov_ff} + {{(W+1-skf_pkg::NOISE_W){1'b0}}, process_noise};
      pn     = pn_sum[W] ? {W{1'b1}} : pn_sum[W-1:0];

      // restoring division step: remainder stays below the divisor while r is nonzero
      trial = {rem_ff, 1'b0} - {1'b0, den_ff};
      ge    = !trial[W+1];

      // zero r: pn/(pn+r) saturates, or is zero when pn is zero too
      if (rzero_ff) begin
         gain = (pn_ff == '0) ? '0 : {G{1'b1}};
      end else begin
         gain = quo_ff;
      end
      prod  = PW'($signed({1'b0, gain}) * diff_ff);
      cprod = CW'(((G+1)'(1 << G) - {1'b0, gain}) * pn_ff);

      // arithmetic shift of the product gives the floor
      sum = (W+3)'(base_ff) + (W+3)'($signed(prod_ff[PW-1:F]));
      if (sum > (W+3)'(signed'({1'b0, {(W-1){1'b1}}}))) begin
         est_new = {1'b0, {(W-1){1'b1}}};
      end else if (sum < (W+3)'(signed'({1'b1, {(W-1){1'b0}}}))) begin
         est_new = {1'b1, {(W-1){1'b0}}};
      end else begin
         est_new = sum[W-1:0];
      end
      cov_new = cprod_ff[CW-1] ? {W{1'b1}} : cprod_ff[CW-2:F];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff       <= '0;
         cov_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            est_ff       <= est_new;
            cov_ff       <= cov_new;
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff   <= jump ? req_sample : est_ff;
         diff_ff   <= jump ? '0 : d;
         jumped_ff <= jump;
         pn_ff     <= pn;
         den_ff    <= {1'b0, pn} + {{(W+1-skf_pkg::NOISE_W){1'b0}}, measurement_noise};
         rem_ff    <= {1'b0, pn};
         quo_ff    <= '0;
         rzero_ff  <= (measurement_noise == '0);
      end
      if (cmd.step) begin
         rem_ff <= ge ? trial[W:0] : {rem_ff[W-1:0], 1'b0};
         quo_ff <= {quo_ff[G-2:0], ge};
      end
      if (cmd.mul) begin
         prod_ff  <= prod;
         cprod_ff <= cprod;
      end
      if (cmd.commit) begin
         out_est_ff  <= est_new;
         out_jump_ff <= jumped_ff;
      end
   end

   assign status.out_full = out_valid_ff;
   assign rsp_valid       = out_valid_ff;
   assign rsp_estimate    = out_est_ff;
   assign rsp_jumped      = out_jump_ff;

`ifndef ASSERT_OFF
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && !rzero_ff) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");
   a_cov_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (cov_ff <= $past(pn_ff)))
      else $error("covariance grew past prediction");
   a_jump_diff: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (!jumped_ff || (diff_ff == '0)))
      else $error("snap left a nonzero difference");
`endif

endmodule

@@ src/scalar_kalman_filter_top.sv @@
// channel   direction  handshake               payload
// req_      in         req_valid / req_stall   req_sample
// rsp_      out        rsp_valid / rsp_stall   rsp_estimate, rsp_jumped
// csr_      in         csr_valid / csr_ready   csr_index, csr_data
//
// An item passes from accept to result through a load, 16 steps of the
// restoring gain divider (one quotient bit per cycle), a multiply and a
// commit. The divider sets the rate; the next item is accepted the cycle after
// commit. Reset clears estimate and covariance to zero and loads the default
// noise and threshold values. A result waits in the output register while
// rsp_stall is high; commit of the next item holds until that register frees.
module scalar_kalman_filter_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [skf_pkg::DATA_W-1:0]   req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [skf_pkg::DATA_W-1:0]   rsp_estimate,
   output logic                                rsp_jumped,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [skf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [skf_pkg::CSR_DATA_W-1:0]      csr_data
);

   skf_pkg::cmd_type    cmd;
   skf_pkg::status_type status;
   logic [skf_pkg::NOISE_W-1:0]  process_noise;
   logic [skf_pkg::NOISE_W-1:0]  measurement_noise;
   logic [skf_pkg::THRESH_W-1:0] jump_threshold;

   skf_csr u_csr (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .process_noise     (process_noise),
      .measurement_noise (measurement_noise),
      .jump_threshold    (jump_threshold)
   );

   skf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   skf_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_sample        (req_sample),
      .process_noise     (process_noise),
      .measurement_noise (measurement_noise),
      .jump_threshold    (jump_threshold),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_estimate      (rsp_estimate),
      .rsp_jumped        (rsp_jumped)
   );

endmodule
